// ===== rtl/htld_pkg.sv =====
// package for the huffman tree load and decode block
// holds sizes, payload structs and the controller/datapath command and status types
package htld_pkg;

    localparam int MAX_NODES   = 512;
    localparam int STACK_DEPTH = 256;

    localparam int NODE_W = $clog2(MAX_NODES);
    localparam int CNT_W  = $clog2(MAX_NODES + 1);
    localparam int STK_AW = $clog2(STACK_DEPTH);
    localparam int LVL_W  = $clog2(STACK_DEPTH + 1);

    localparam int PADDR_W = 3;
    localparam logic [PADDR_W-1:0] ADDR_PAD_BITS = 3'd0;

    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_ERR = 1'b1;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       final_byte;
    } t_in;

    typedef struct packed {
        logic [7:0] symbol;
        logic       status;
        logic       run_end;
    } t_out;

    typedef struct packed {
        logic accept;
        logic load;
        logic step;
        logic take_leaf;
        logic take_inner;
        logic flush;
        logic err;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic hold;
        logic phase;
        logic load_err;
        logic load_done;
        logic bit_last;
        logic is_leaf;
        logic pend;
        logic out_free;
    } t_sts;

endpackage

// ===== rtl/huffman_tree_load_and_decode_top.sv =====
// tree loading: one stream bit per cycle, then S_FIN closes the transaction
// decoding: each bit takes a node table read in S_STEP and a check of the dependent result in S_CHK
// a decoded symbol is held back until the next one or the end of its byte
// synchronous active-low reset empties the tree and stack; tables need no clearing pass
// top level of the huffman tree load and decode block
// depends on htld_pkg, htld_ctrl and htld_dp
module huffman_tree_load_and_decode_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  htld_pkg::t_in                 i_data,
    output logic                          o_valid,
    input  logic                          i_stall,
    output htld_pkg::t_out                o_data,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [htld_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import htld_pkg::*;

    logic [2:0] r_pad;
    t_cmd       cmd;
    t_sts       sts;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pad <= 3'd0;
        end else if (psel && penable && pwrite && (paddr == ADDR_PAD_BITS)) begin
            r_pad <= pwdata[2:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_PAD_BITS) ? {29'd0, r_pad} : 32'd0;

    htld_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_stall (o_stall)
    );

    htld_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_data),
        .i_pad   (r_pad),
        .i_cmd   (cmd),
        .o_sts   (sts),
        .i_stall (i_stall),
        .o_valid (o_valid),
        .o_out   (o_data)
    );

endmodule

// ===== rtl/htld_ctrl.sv =====
// controller state machine for the huffman tree load and decode block
// depends on htld_pkg for the command and status structs
module htld_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  htld_pkg::t_sts  i_sts,
    output htld_pkg::t_cmd  o_cmd,
    output logic            o_stall
);
    import htld_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_STEP,
        S_CHK,
        S_FLUSH,
        S_FIN
    } t_state;

    t_state r_state;
    t_state n_state;
    t_cmd   cmd;

    always_comb begin
        cmd     = '0;
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    cmd.accept = 1'b1;
                    if (i_sts.hold) begin
                        n_state = S_FIN;
                    end else if (i_sts.phase) begin
                        n_state = S_STEP;
                    end else begin
                        n_state = S_LOAD;
                    end
                end
            end
            S_LOAD: begin
                if (i_sts.load_err) begin
                    if (i_sts.out_free) begin
                        cmd.err = 1'b1;
                        n_state = S_FIN;
                    end
                end else begin
                    cmd.load = 1'b1;
                    if (i_sts.load_done || i_sts.bit_last) begin
                        n_state = S_FIN;
                    end
                end
            end
            S_STEP: begin
                cmd.step = 1'b1;
                n_state  = S_CHK;
            end
            S_CHK: begin
                if (i_sts.is_leaf) begin
                    if (!i_sts.pend || i_sts.out_free) begin
                        cmd.take_leaf = 1'b1;
                        n_state = i_sts.bit_last ? S_FLUSH : S_STEP;
                    end
                end else begin
                    cmd.take_inner = 1'b1;
                    n_state = i_sts.bit_last ? S_FLUSH : S_STEP;
                end
            end
            S_FLUSH: begin
                if (!i_sts.pend) begin
                    n_state = S_FIN;
                end else if (i_sts.out_free) begin
                    cmd.flush = 1'b1;
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                cmd.finish = 1'b1;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_cmd   = cmd;
    assign o_stall = (r_state != S_IDLE);

endmodule

// ===== rtl/htld_dp.sv =====
// datapath: node tables, pending stack, loader registers, tree walk and result registers
// depends on htld_pkg; driven by htld_ctrl through command and status structs
module htld_dp (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  htld_pkg::t_in   i_in,
    input  logic [2:0]      i_pad,
    input  htld_pkg::t_cmd  i_cmd,
    output htld_pkg::t_sts  o_sts,
    input  logic            i_stall,
    output logic            o_valid,
    output htld_pkg::t_out  o_out
);
    import htld_pkg::*;

    // node kind memory holds {is_leaf, symbol}, right memory the right link
    logic [8:0]        kind_mem  [MAX_NODES];
    logic [NODE_W-1:0] right_mem [MAX_NODES];
    logic [NODE_W-1:0] stk_mem   [STACK_DEPTH];

    logic [7:0]        r_byte;
    logic              r_fin;
    logic [2:0]        r_bit;
    logic [2:0]        r_last;
    logic [LVL_W-1:0]  r_level;
    logic [CNT_W-1:0]  r_nodes;
    logic              r_phase;
    logic [3:0]        r_leaf_left;
    logic [7:0]        r_shift;
    logic [NODE_W-1:0] r_walk;
    logic [NODE_W-1:0] r_next;
    logic              r_hold;
    logic              r_root_leaf;
    logic [NODE_W-1:0] r_root_right;
    logic [8:0]        r_kind_rd;
    logic [NODE_W-1:0] r_right_rd;
    logic [NODE_W-1:0] r_stk_rd;
    logic              r_pv;
    logic [7:0]        r_pend;
    logic              r_ov;
    t_out              r_out;

    logic              cur_bit;
    logic              load_err;
    logic              load_done;
    logic              out_free;
    logic [7:0]        shift_new;
    logic [NODE_W-1:0] nodes_link;
    logic [CNT_W-1:0]  walk_inc;
    logic [NODE_W-1:0] walk_safe_inc;
    logic [NODE_W-1:0] right_v;
    logic [NODE_W-1:0] next_c;
    logic [LVL_W-1:0]  level_dec;

    logic              kind_we;
    logic [NODE_W-1:0] kind_wa;
    logic [8:0]        kind_wd;
    logic              right_we;
    logic [NODE_W-1:0] right_wa;
    logic              stk_we;

    assign cur_bit   = r_byte[r_bit];
    assign out_free  = !r_ov || !i_stall;
    assign shift_new = {r_shift[6:0], cur_bit};
    assign level_dec = r_level - 1'b1;

    // a link to the node after the last slot wraps to the root
    assign nodes_link = (r_nodes == CNT_W'(MAX_NODES)) ? '0 : r_nodes[NODE_W-1:0];
    assign walk_inc      = CNT_W'(r_walk) + 1'b1;
    assign walk_safe_inc = (walk_inc == CNT_W'(MAX_NODES)) ? '0 : walk_inc[NODE_W-1:0];
    assign right_v = (r_walk == '0) ? r_root_right : r_right_rd;
    assign next_c  = r_root_leaf ? '0 : (cur_bit ? right_v : walk_safe_inc);

    assign load_err = (r_leaf_left == 4'd0) &&
                      ((r_nodes >= CNT_W'(MAX_NODES)) ||
                       (cur_bit && (r_level >= LVL_W'(STACK_DEPTH))));
    assign load_done = (r_leaf_left == 4'd1) && (r_level == '0);

    always_comb begin
        kind_we  = 1'b0;
        kind_wa  = r_nodes[NODE_W-1:0];
        kind_wd  = '0;
        right_we = 1'b0;
        right_wa = r_stk_rd;
        stk_we   = 1'b0;
        if (i_cmd.load) begin
            if (r_leaf_left != 4'd0) begin
                if (r_leaf_left == 4'd1) begin
                    kind_we = 1'b1;
                    kind_wa = NODE_W'(r_nodes - 1'b1);
                    kind_wd = {1'b1, shift_new};
                    if (r_level != '0) begin
                        right_we = 1'b1;
                    end
                end
            end else if (cur_bit) begin
                kind_we = 1'b1;
                stk_we  = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (kind_we) begin
            kind_mem[kind_wa] <= kind_wd;
        end
        if (right_we) begin
            right_mem[right_wa] <= nodes_link;
        end
        if (stk_we) begin
            stk_mem[r_level[STK_AW-1:0]] <= r_nodes[NODE_W-1:0];
        end
        // top of stack is read every cycle, a pop comes well after the last push
        r_stk_rd <= stk_mem[level_dec[STK_AW-1:0]];
        if (i_cmd.step) begin
            r_kind_rd  <= kind_mem[next_c];
            r_right_rd <= right_mem[next_c];
            r_next     <= next_c;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_byte <= i_in.data_byte;
            r_fin  <= i_in.final_byte;
            r_last <= (i_in.final_byte && r_phase) ? i_pad : 3'd0;
        end
        if (right_we && (r_stk_rd == '0)) begin
            r_root_right <= nodes_link;
        end
        if (i_cmd.take_leaf) begin
            r_pend <= r_kind_rd[7:0];
        end
        if (i_cmd.take_leaf && r_pv) begin
            r_out <= '{symbol: r_pend, status: STATUS_OK, run_end: 1'b0};
        end else if (i_cmd.flush) begin
            r_out <= '{symbol: r_pend, status: STATUS_OK, run_end: 1'b1};
        end else if (i_cmd.err) begin
            r_out <= '{symbol: 8'd0, status: STATUS_ERR, run_end: 1'b1};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit       <= 3'd7;
            r_level     <= '0;
            r_nodes     <= '0;
            r_phase     <= 1'b0;
            r_leaf_left <= 4'd0;
            r_shift     <= 8'd0;
            r_walk      <= '0;
            r_hold      <= 1'b0;
            r_root_leaf <= 1'b0;
            r_pv        <= 1'b0;
            r_ov        <= 1'b0;
        end else begin
            if ((i_cmd.take_leaf && r_pv) || i_cmd.flush || i_cmd.err) begin
                r_ov <= 1'b1;
            end else if (r_ov && !i_stall) begin
                r_ov <= 1'b0;
            end
            if (i_cmd.accept) begin
                r_bit <= 3'd7;
            end
            if (i_cmd.load || i_cmd.take_leaf || i_cmd.take_inner) begin
                r_bit <= r_bit - 1'b1;
            end
            if (i_cmd.load) begin
                if (r_leaf_left != 4'd0) begin
                    r_shift     <= shift_new;
                    r_leaf_left <= r_leaf_left - 1'b1;
                    if (r_leaf_left == 4'd1) begin
                        if (r_level == '0) begin
                            r_phase <= 1'b1;
                            r_walk  <= '0;
                        end else begin
                            r_level <= level_dec;
                        end
                    end
                end else begin
                    if (cur_bit) begin
                        r_level <= r_level + 1'b1;
                    end else begin
                        r_leaf_left <= 4'd8;
                        r_shift     <= 8'd0;
                        if (r_nodes == '0) begin
                            r_root_leaf <= 1'b1;
                        end
                    end
                    r_nodes <= r_nodes + 1'b1;
                end
            end
            if (i_cmd.take_leaf) begin
                r_pv   <= 1'b1;
                r_walk <= '0;
            end
            if (i_cmd.take_inner) begin
                r_walk <= r_next;
            end
            if (i_cmd.flush) begin
                r_pv <= 1'b0;
            end
            if (i_cmd.err) begin
                r_hold <= 1'b1;
            end
            if (i_cmd.finish && r_fin) begin
                r_level     <= '0;
                r_nodes     <= '0;
                r_phase     <= 1'b0;
                r_leaf_left <= 4'd0;
                r_shift     <= 8'd0;
                r_walk      <= '0;
                r_hold      <= 1'b0;
                r_root_leaf <= 1'b0;
            end
        end
    end

    assign o_sts = '{
        hold:      r_hold,
        phase:     r_phase,
        load_err:  load_err,
        load_done: load_done,
        bit_last:  (r_bit == r_last),
        is_leaf:   r_kind_rd[8],
        pend:      r_pv,
        out_free:  out_free
    };
    assign o_valid = r_ov;
    assign o_out   = r_out;

endmodule

// ===== bench/tb_top.sv =====
// self-checking bench for huffman_tree_load_and_decode_top: random trees, streams and noise
// predicts the symbol transactions in its own tree decoder; depends on htld_pkg and the rtl
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import htld_pkg::*;

    logic i_clk, i_rst_n, i_valid, o_stall, o_valid, i_stall;
    t_in i_data;
    t_out o_data;
    logic psel, penable, pwrite, pready;
    logic [PADDR_W-1:0] paddr;
    logic [31:0] pwdata, prdata;

    huffman_tree_load_and_decode_top dut (.*);

    // decoder copy
    logic       nd_leaf [MAX_NODES];
    logic [7:0] nd_sym [MAX_NODES];
    int         nd_left [MAX_NODES];
    int         nd_right [MAX_NODES];
    int         pend_nodes [STACK_DEPTH];
    int lvl, used, walking, leaf_left, walk;
    logic       hold;
    logic [7:0] sym_acc;
    logic [2:0] pad_cfg;

    t_in  byte_q [$];
    t_out symbol_q [$];
    bit   stream_bits [$];
    int   idle_pct, stall_pct, hold_cnt, mismatches;
    bit   hold_req;

    function automatic void clear_decoder();
        lvl = 0; used = 0; walking = 0; leaf_left = 0; walk = 0;
        hold = 1'b0; sym_acc = 8'd0;
    endfunction

    function automatic int wrap_node(int i);
        return (i >= 0 && i < MAX_NODES) ? i : 0;
    endfunction

    // 0 continue, 1 tree complete, 2 overflow
    function automatic int load_bit(bit b);
        if (leaf_left != 0) begin
            sym_acc = {sym_acc[6:0], b};
            leaf_left--;
            if (leaf_left != 0) return 0;
            nd_sym[wrap_node(used - 1)] = sym_acc;
            if (lvl == 0) return 1;
            lvl--;
            nd_right[wrap_node(pend_nodes[lvl])] = used;
            return 0;
        end
        if (used >= MAX_NODES) return 2;
        if (b) begin
            if (lvl >= STACK_DEPTH) return 2;
            nd_leaf[used] = 1'b0; nd_left[used] = used + 1; nd_right[used] = 0;
            pend_nodes[lvl] = used;
            lvl++;
        end else begin
            nd_leaf[used] = 1'b1; nd_left[used] = 0; nd_right[used] = 0;
            leaf_left = 8; sym_acc = 8'd0;
        end
        nd_sym[used] = 8'd0;
        used++;
        return 0;
    endfunction

    function automatic void decode_byte(t_in it);
        t_out r;
        int res, nxt, last, n0;
        n0 = symbol_q.size();
        if (hold) begin
        end else if (!walking) begin
            for (int b = 7; b >= 0; b--) begin
                res = load_bit(it.data_byte[b]);
                if (res == 1) begin
                    walking = 1; walk = 0;
                    break;
                end
                if (res == 2) begin
                    hold = 1'b1;
                    r.symbol = 8'd0; r.status = STATUS_ERR; r.run_end = 1'b1;
                    symbol_q.push_back(r);
                    break;
                end
            end
        end else begin
            last = it.final_byte ? int'(pad_cfg) : 0;
            for (int b = 7; b >= last; b--) begin
                if (nd_leaf[0]) nxt = 0;
                else nxt = wrap_node(it.data_byte[b] ? nd_right[wrap_node(walk)]
                                                     : nd_left[wrap_node(walk)]);
                if (nd_leaf[nxt]) begin
                    r.symbol = nd_sym[nxt]; r.status = STATUS_OK; r.run_end = 1'b0;
                    symbol_q.push_back(r);
                    walk = 0;
                end else walk = nxt;
            end
            if (symbol_q.size() > n0) symbol_q[$].run_end = 1'b1;
        end
        if (it.final_byte) clear_decoder();
    endfunction

    // stream building
    function automatic void put_bits(int v, int n);
        for (int k = n - 1; k >= 0; k--) stream_bits.push_back(v[k]);
    endfunction

    function automatic void grow_tree(int depth);
        if (depth >= 6 || $urandom_range(9) < 2 + depth) begin
            put_bits(0, 1);
            put_bits($urandom_range(255), 8);
        end else begin
            put_bits(1, 1);
            grow_tree(depth + 1);
            grow_tree(depth + 1);
        end
    endfunction

    // packs the bit queue into bytes, the last one flagged final unless cut short
    function automatic void queue_bytes(bit mark_final);
        t_in it;
        while (stream_bits.size() % 8 != 0) stream_bits.push_back(1'($urandom_range(1)));
        while (stream_bits.size() > 0) begin
            for (int k = 7; k >= 0; k--) it.data_byte[k] = stream_bits.pop_front();
            it.final_byte = mark_final && stream_bits.size() == 0;
            byte_q.push_back(it);
        end
    endfunction

    function automatic void tree_stream(int data_bytes, bit root_leaf);
        stream_bits.delete();
        if (root_leaf) begin
            put_bits(0, 1);
            put_bits($urandom_range(255), 8);
        end else grow_tree(0);
        while (stream_bits.size() % 8 != 0) stream_bits.push_back(1'($urandom_range(1)));
        for (int k = 0; k < data_bytes * 8; k++) stream_bits.push_back(1'($urandom_range(1)));
        queue_bytes(1'b1);
    endfunction

    // sender
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) decode_byte(i_data);
            if (!i_valid || !o_stall) begin
                if (byte_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
                    i_data  <= byte_q.pop_front();
                    i_valid <= 1'b1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // receiver with a long hold-off on request
    always @(posedge i_clk) begin
        if (hold_req) begin
            hold_req = 1'b0;
            hold_cnt <= 400;
            i_stall  <= 1'b1;
        end else if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
            i_stall  <= 1'b1;
        end else begin
            i_stall <= $urandom_range(99) < stall_pct;
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (symbol_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected symbol transaction %p", o_data);
            end else begin
                want = symbol_q.pop_front();
                if (o_data.symbol !== want.symbol || o_data.status !== want.status ||
                    o_data.run_end !== want.run_end) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p got %p", want, o_data);
                end
            end
        end
    end

    task automatic wait_drained();
        while (byte_q.size() > 0 || i_valid || symbol_q.size() > 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_pad(logic [2:0] v);
        @(posedge i_clk);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= ADDR_PAD_BITS; pwdata <= {$urandom} & ~32'h7 | v;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        pad_cfg = v;
    endtask

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #5ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        t_in it;
        i_rst_n = 1'b0; i_valid = 1'b0; i_stall = 1'b0; i_data = '0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        idle_pct = 0; stall_pct = 0; hold_cnt = 0; hold_req = 1'b0; mismatches = 0;
        pad_cfg = 3'd0;
        clear_decoder();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: root leaf, small trees, final while loading, cut-off tree, pad extremes
        write_pad(3'd7);
        tree_stream(2, 1'b1);
        tree_stream(3, 1'b0);
        tree_stream(0, 1'b0);
        stream_bits.delete();
        put_bits(1, 1); put_bits(1, 1); put_bits(0, 1); put_bits(8'hff, 8);
        queue_bytes(1'b1);
        it.data_byte = 8'h00; it.final_byte = 1'b1; byte_q.push_back(it);
        it.data_byte = 8'hff; it.final_byte = 1'b1; byte_q.push_back(it);
        wait_drained();
        write_pad(3'd0);
        tree_stream(3, 1'b0);
        tree_stream(1, 1'b1);
        wait_drained();

        for (int ph = 0; ph < 4; ph++) begin
            idle_pct  = (ph == 1 || ph == 3) ? (ph == 1 ? 75 : 15) : 0;
            stall_pct = (ph == 2 || ph == 3) ? (ph == 2 ? 75 : 15) : 0;
            write_pad(ph == 0 ? 3'd7 : 3'($urandom_range(7)));
            if (ph == 0) hold_req = 1'b1;
            while (byte_q.size() < 15) begin
                case ($urandom_range(9))
                    0: begin
                        // noise bytes with random final flags, always closed by a final byte
                        repeat ($urandom_range(1, 4)) begin
                            it.data_byte = 8'($urandom_range(255));
                            it.final_byte = 1'($urandom_range(1));
                            byte_q.push_back(it);
                        end
                        it.data_byte = 8'($urandom_range(255)); it.final_byte = 1'b1;
                        byte_q.push_back(it);
                    end
                    1: begin
                        // truncated tree then a final byte
                        stream_bits.delete();
                        grow_tree(0);
                        while (stream_bits.size() > 4) void'(stream_bits.pop_back());
                        queue_bytes(1'b0);
                        it.data_byte = 8'($urandom_range(255)); it.final_byte = 1'b1;
                        byte_q.push_back(it);
                    end
                    default: tree_stream($urandom_range(1, 8), $urandom_range(15) == 0);
                endcase
            end
            // stack overflow: a run of internal nodes, then junk held off until final
            if (ph == 1) begin
                repeat (34) begin
                    it.data_byte = 8'hff; it.final_byte = 1'b0; byte_q.push_back(it);
                end
                it.data_byte = 8'h5a; it.final_byte = 1'b1; byte_q.push_back(it);
            end
            // node table overflow: a deep run of internal nodes, then leaf/internal
            // pairs that keep the stack just below its limit
            if (ph == 2) begin
                stream_bits.delete();
                repeat (STACK_DEPTH - 2) put_bits(1, 1);
                repeat ((MAX_NODES - STACK_DEPTH) / 2 + 2) begin
                    put_bits(0, 1); put_bits($urandom_range(255), 8); put_bits(1, 1);
                end
                queue_bytes(1'b1);
            end
            wait_drained();
        end

        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
